[hdl/adl_pkg.sv]
// Shared types and constants for the adjacent line dedup unit.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package adl_pkg;

   localparam logic [7:0]  NEWLINE   = 8'd10;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // configuration register map
   localparam int CSR_IDX_W = 2;
   localparam int CW_W      = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_UNIQUE_ONLY   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COMPARE_WIDTH = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETTLE,
      ST_FLUSH_RD,
      ST_FLUSH_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic store_byte;
      logic take_line;
      logic bump_count;
      logic clear_stream;
      logic start_flush;
      logic flush_read;
      logic load_word;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_eoi;
      logic is_newline;
      logic have_line;
      logic differs;
      logic emit_ok;
      logic last_word;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

[hdl/adl_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module adl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

[hdl/adl_ctrl.sv]
// Controller state machine for the adjacent line dedup unit.
// Depends on adl_pkg; drives the datapath through cmd_type, reads status_type.
`timescale 1ns / 1ps
`default_nettype none
module adl_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire adl_pkg::status_type status,
   output adl_pkg::cmd_type        cmd
);

   adl_pkg::state_type state_ff, state_in;
   logic               pend_clear_ff, pend_clear_in;
   logic               accept;

   assign req_ready = (state_ff == adl_pkg::ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= adl_pkg::ST_IDLE;
         pend_clear_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_clear_ff <= pend_clear_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      pend_clear_in = pend_clear_ff;
      cmd           = '0;
      unique case (state_ff)
         adl_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = adl_pkg::ST_SETTLE;
               if (status.is_eoi) begin
                  if (status.emit_ok) begin
                     cmd.start_flush = 1'b1;
                     pend_clear_in   = 1'b1;
                     state_in        = adl_pkg::ST_FLUSH_RD;
                  end else begin
                     cmd.clear_stream = 1'b1;
                  end
               end else if (!status.is_newline) begin
                  cmd.store_byte = 1'b1;
               end else if (!status.have_line) begin
                  cmd.take_line = 1'b1;
               end else if (!status.differs) begin
                  cmd.bump_count = 1'b1;
               end else if (status.emit_ok) begin
                  cmd.start_flush = 1'b1;
                  pend_clear_in   = 1'b0;
                  state_in        = adl_pkg::ST_FLUSH_RD;
               end else begin
                  cmd.take_line = 1'b1;
               end
            end
         end
         adl_pkg::ST_SETTLE: begin
            // let the held word read catch up with the new position
            state_in = adl_pkg::ST_IDLE;
         end
         adl_pkg::ST_FLUSH_RD: begin
            cmd.flush_read = 1'b1;
            state_in       = adl_pkg::ST_FLUSH_OUT;
         end
         adl_pkg::ST_FLUSH_OUT: begin
            cmd.flush_read = 1'b1;
            if (status.out_free) begin
               cmd.load_word = 1'b1;
               if (status.last_word) begin
                  cmd.clear_stream = pend_clear_ff;
                  cmd.take_line    = !pend_clear_ff;
                  state_in         = adl_pkg::ST_SETTLE;
               end else begin
                  state_in = adl_pkg::ST_FLUSH_RD;
               end
            end
         end
         default: begin
            state_in = adl_pkg::ST_IDLE;
         end
      endcase
   end

   a_settle_returns: assert property (@(posedge clock) disable iff (reset)
      state_ff == adl_pkg::ST_SETTLE |=> state_ff == adl_pkg::ST_IDLE)
      else $error("settle cycle did not return to idle");

   a_flush_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.start_flush |=> state_ff == adl_pkg::ST_FLUSH_RD)
      else $error("flush start did not enter the read step");

   a_no_take_and_clear: assert property (@(posedge clock) disable iff (reset)
      !(cmd.take_line && cmd.clear_stream))
      else $error("take and clear issued together");

endmodule
`default_nettype wire

[hdl/adl_datapath.sv]
// Datapath of the adjacent line dedup unit: line buffers, compare, run count,
// configuration registers and the result register. Depends on adl_pkg, adl_ram.
`timescale 1ns / 1ps
`default_nettype none
module adl_datapath #(
   parameter int LINE_MAX = 512
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [7:0]                       req_in_byte,
   input  wire logic                             req_end_of_input,
   input  wire logic                             csr_valid,
   input  wire logic [adl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [adl_pkg::CW_W-1:0]         csr_data,
   input  wire adl_pkg::cmd_type                 cmd,
   output adl_pkg::status_type                   status,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [63:0]                           rsp_text_word,
   output logic [3:0]                            rsp_byte_count,
   output logic [15:0]                           rsp_run_count,
   output logic                                  rsp_last_word
);

   localparam int LEN_W = $clog2(LINE_MAX + 1);
   localparam int WORDS = (LINE_MAX + 7) / 8;
   localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

   function automatic logic [adl_pkg::CW_W-1:0] span(input logic [adl_pkg::CW_W-1:0] cw,
                                                     input logic [adl_pkg::CW_W-1:0] len);
      if (cw != '0 && cw < len) begin
         return cw;
      end
      return len;
   endfunction

   // configuration
   logic                      count_mode_ff, unique_only_ff;
   logic [adl_pkg::CW_W-1:0]  compare_width_ff;

   // stream state
   logic [LEN_W-1:0] held_len_ff, held_len_in;
   logic [LEN_W-1:0] in_len_ff, in_len_in;
   logic [15:0]      rep_ff, rep_in;
   logic             have_ff, have_in;
   logic             hsel_ff, hsel_in;
   logic             mm_found_ff, mm_found_in;
   logic [LEN_W-1:0] mm_pos_ff, mm_pos_in;
   logic [63:0]      wbuf_ff, wbuf_in;
   logic [AW-1:0]    w_ff, w_in;

   // result register
   logic        rsp_valid_ff;
   logic [63:0] text_ff, text_in;
   logic [3:0]  count_ff, count_in;
   logic [15:0] run_ff;
   logic        last_ff;

   logic [63:0]            rd0, rd1, held_word, merged;
   logic [7:0]             held_byte;
   logic [AW-1:0]          rd_addr, wr_addr;
   logic                   pos_ok, wr_en;
   logic [adl_pkg::CW_W-1:0] span_held, span_in;
   logic [LEN_W-1:0]       rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_mode_ff    <= 1'b0;
         unique_only_ff   <= 1'b0;
         compare_width_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            adl_pkg::CSR_COUNT_MODE:    count_mode_ff    <= csr_data[0];
            adl_pkg::CSR_UNIQUE_ONLY:   unique_only_ff   <= csr_data[0];
            adl_pkg::CSR_COMPARE_WIDTH: compare_width_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // ping-pong line buffers: bank hsel_ff holds the kept line, the other fills
   assign pos_ok  = in_len_ff < LEN_W'(LINE_MAX);
   assign wr_en   = cmd.store_byte && pos_ok;
   assign wr_addr = AW'(in_len_ff >> 3);
   assign rd_addr = cmd.flush_read ? w_ff : AW'(in_len_ff >> 3);

   adl_ram #(.WIDTH(64), .DEPTH(WORDS)) u_bank0 (
      .clock   (clock),
      .wr_en   (wr_en && hsel_ff),
      .wr_addr (wr_addr),
      .wr_data (merged),
      .rd_addr (rd_addr),
      .rd_data (rd0)
   );

   adl_ram #(.WIDTH(64), .DEPTH(WORDS)) u_bank1 (
      .clock   (clock),
      .wr_en   (wr_en && !hsel_ff),
      .wr_addr (wr_addr),
      .wr_data (merged),
      .rd_addr (rd_addr),
      .rd_data (rd1)
   );

   assign held_word = hsel_ff ? rd1 : rd0;
   assign held_byte = held_word[{in_len_ff[2:0], 3'b000} +: 8];

   always_comb begin
      merged = wbuf_ff;
      merged[{in_len_ff[2:0], 3'b000} +: 8] = req_in_byte;
   end

   assign span_held = span(compare_width_ff, adl_pkg::CW_W'(held_len_ff));
   assign span_in   = span(compare_width_ff, adl_pkg::CW_W'(in_len_ff));

   assign status.is_eoi     = req_end_of_input;
   assign status.is_newline = (req_in_byte == adl_pkg::NEWLINE);
   assign status.have_line  = have_ff;
   assign status.differs    = (span_held != span_in) ||
                              (mm_found_ff && adl_pkg::CW_W'(mm_pos_ff) < span_held);
   assign status.emit_ok    = have_ff && !(unique_only_ff && rep_ff != 16'd1);
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   // bytes left in the held line from the current flush word on
   assign rem              = held_len_ff - (LEN_W'(w_ff) << 3);
   assign status.last_word = rem <= LEN_W'(8);
   assign count_in         = (rem >= LEN_W'(8)) ? 4'd8 : 4'(rem);

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         text_in[b*8 +: 8] = (4'(b) < count_in) ? held_word[b*8 +: 8] : 8'h00;
      end
   end

   always_comb begin
      held_len_in = held_len_ff;
      in_len_in   = in_len_ff;
      rep_in      = rep_ff;
      have_in     = have_ff;
      hsel_in     = hsel_ff;
      mm_found_in = mm_found_ff;
      mm_pos_in   = mm_pos_ff;
      wbuf_in     = wbuf_ff;
      w_in        = w_ff;
      if (wr_en) begin
         wbuf_in   = merged;
         in_len_in = in_len_ff + LEN_W'(1);
         // note the first position where the two lines part
         if (in_len_ff < held_len_ff && !mm_found_ff && req_in_byte != held_byte) begin
            mm_found_in = 1'b1;
            mm_pos_in   = in_len_ff;
         end
      end
      if (cmd.bump_count) begin
         rep_in      = (rep_ff == adl_pkg::COUNT_MAX) ? rep_ff : rep_ff + 16'd1;
         in_len_in   = '0;
         mm_found_in = 1'b0;
      end
      if (cmd.take_line) begin
         hsel_in     = !hsel_ff;
         held_len_in = in_len_ff;
         rep_in      = 16'd1;
         have_in     = 1'b1;
         in_len_in   = '0;
         mm_found_in = 1'b0;
      end
      if (cmd.clear_stream) begin
         held_len_in = '0;
         in_len_in   = '0;
         rep_in      = '0;
         have_in     = 1'b0;
         mm_found_in = 1'b0;
      end
      if (cmd.start_flush) begin
         w_in = '0;
      end
      if (cmd.load_word) begin
         w_in = w_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_len_ff  <= '0;
         in_len_ff    <= '0;
         rep_ff       <= '0;
         have_ff      <= 1'b0;
         hsel_ff      <= 1'b0;
         mm_found_ff  <= 1'b0;
         w_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         held_len_ff <= held_len_in;
         in_len_ff   <= in_len_in;
         rep_ff      <= rep_in;
         have_ff     <= have_in;
         hsel_ff     <= hsel_in;
         mm_found_ff <= mm_found_in;
         w_ff        <= w_in;
         if (cmd.load_word) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mm_pos_ff <= mm_pos_in;
      wbuf_ff   <= wbuf_in;
      if (cmd.load_word) begin
         text_ff  <= text_in;
         count_ff <= count_in;
         run_ff   <= count_mode_ff ? rep_ff : 16'd0;
         last_ff  <= status.last_word;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_text_word  = text_ff;
   assign rsp_byte_count = count_ff;
   assign rsp_run_count  = run_ff;
   assign rsp_last_word  = last_ff;

   a_have_has_count: assert property (@(posedge clock) disable iff (reset)
      have_ff |-> rep_ff != 16'd0)
      else $error("held line with zero run count");

   a_empty_no_length: assert property (@(posedge clock) disable iff (reset)
      !have_ff |-> held_len_ff == '0)
      else $error("held length set without a held line");

   a_len_bounded: assert property (@(posedge clock) disable iff (reset)
      in_len_ff <= LEN_W'(LINE_MAX) && held_len_ff <= LEN_W'(LINE_MAX))
      else $error("line length beyond the buffer");

endmodule
`default_nettype wire

[hdl/adjacent_line_dedup_unit.sv]
// Top level of the adjacent line dedup unit.
// Depends on adl_pkg, adl_ctrl, adl_datapath (and adl_ram below it).
//
// Usage:
//   req_ channel: one text byte per transaction; a newline (10) ends a line,
//   req_end_of_input flushes the last run and returns the stream to its start.
//   rsp_ channel: the first line of each finished run as 64-bit words, first
//   character in the lowest byte, with byte count, run count and last-word flag.
//   csr_ channel: index 0 count mode, 1 unique only, 2 compare width (0 = whole
//   line); always ready, write only between transactions.
// Sequencing:
//   A byte or a newline that extends a run is taken in the idle state, then a
//   settle state lets the held-line buffer read follow the new position.
//   A newline that ends a run, or end of input, walks the held line through the
//   buffer read port word by word, a read state then an output state per word,
//   and waits in the output state while the result is held and rsp_ready is low.
// Reset clears all control state and configuration; the line buffers are not
// cleared. A stalled result waits in the output register while the next byte
// is still taken; only a further flush waits for it.
`timescale 1ns / 1ps
`default_nettype none
module adjacent_line_dedup_unit #(
   parameter int LINE_MAX = 512
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [7:0]                       req_in_byte,
   input  wire logic                             req_end_of_input,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [63:0]                           rsp_text_word,
   output logic [3:0]                            rsp_byte_count,
   output logic [15:0]                           rsp_run_count,
   output logic                                  rsp_last_word,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [adl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [adl_pkg::CW_W-1:0]         csr_data
);

   adl_pkg::cmd_type    cmd;
   adl_pkg::status_type status;

   assign csr_ready = 1'b1;

   adl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   adl_datapath #(.LINE_MAX(LINE_MAX)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_in_byte      (req_in_byte),
      .req_end_of_input (req_end_of_input),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_text_word    (rsp_text_word),
      .rsp_byte_count   (rsp_byte_count),
      .rsp_run_count    (rsp_run_count),
      .rsp_last_word    (rsp_last_word)
   );

endmodule
`default_nettype wire

[test/adjacent_line_dedup_unit_tb.sv]
// Testbench for adjacent_line_dedup_unit: streams text bytes through the block and checks
// every emitted word against an in-bench line filter predictor. Depends on adl_pkg and the RTL.
`timescale 1ns / 1ps
module adjacent_line_dedup_unit_tb;

   localparam int LINE_MAX       = 512;
   localparam int CYCLE_LIMIT    = 40_000_000;
   localparam int SETTLE_CYCLES  = 2 * 64 + 20;
   localparam int HOLD_CYCLES    = 400;
   localparam int RANDOM_ITEMS   = 250;

   typedef struct {
      bit [63:0] text;
      bit [3:0]  nbytes;
      bit [15:0] count;
      bit        last;
   } line_word_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [7:0]                    req_in_byte = 8'd0;
   logic                          req_end_of_input = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [63:0]                   rsp_text_word;
   logic [3:0]                    rsp_byte_count;
   logic [15:0]                   rsp_run_count;
   logic                          rsp_last_word;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [adl_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [adl_pkg::CW_W-1:0]      csr_data = '0;

   // predictor state
   bit [7:0]    held_text [LINE_MAX];
   bit [7:0]    incoming_text [LINE_MAX];
   int unsigned held_len = 0;
   int unsigned incoming_len = 0;
   bit [15:0]   run_len = 0;
   bit          line_held = 0;
   bit          cfg_count_mode = 0;
   bit          cfg_unique_only = 0;
   bit [9:0]    cfg_compare_width = 0;

   line_word_type expected_words[$];
   line_word_type head_word;
   int unsigned errors = 0;
   int unsigned items_sent = 0;
   int unsigned cycle_count = 0;
   bit          send_gaps_on = 1'b0;
   bit          ready_gaps_on = 1'b0;
   bit          long_hold_req = 1'b0;

   adjacent_line_dedup_unit #(.LINE_MAX(LINE_MAX)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_in_byte(req_in_byte), .req_end_of_input(req_end_of_input),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_text_word(rsp_text_word), .rsp_byte_count(rsp_byte_count),
      .rsp_run_count(rsp_run_count), .rsp_last_word(rsp_last_word),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
   endfunction

   function automatic bit [7:0] random_text_byte();
      bit [7:0] v;
      v = 8'($urandom_range(0, 254));
      if (v >= adl_pkg::NEWLINE) v++;
      return v;
   endfunction

   function automatic int unsigned compared_span(int unsigned len);
      if (cfg_compare_width != 0 && cfg_compare_width < len) return cfg_compare_width;
      return len;
   endfunction

   // queue the words of the held run, if the mode lets it out
   task automatic emit_held_run();
      int unsigned   words;
      int unsigned   pos;
      line_word_type w;
      if (!line_held) return;
      if (cfg_unique_only && run_len != 1) return;
      words = (held_len + 7) / 8;
      if (words == 0) words = 1;
      for (int unsigned wi = 0; wi < words; wi++) begin
         w.text   = '0;
         w.nbytes = '0;
         for (int unsigned b = 0; b < 8; b++) begin
            pos = wi * 8 + b;
            if (pos < held_len) begin
               w.text[8*b +: 8] = held_text[pos];
               w.nbytes++;
            end
         end
         w.count = cfg_count_mode ? run_len : 16'd0;
         w.last  = (wi + 1 == words);
         expected_words.push_back(w);
      end
   endtask

   task automatic start_new_run();
      for (int unsigned i = 0; i < incoming_len; i++) held_text[i] = incoming_text[i];
      held_len  = incoming_len;
      run_len   = 1;
      line_held = 1'b1;
   endtask

   task automatic predict_dedup(bit [7:0] ch, bit eoi);
      int unsigned held_span;
      int unsigned new_span;
      bit          mismatch;
      if (eoi) begin
         emit_held_run();
         held_len     = 0;
         incoming_len = 0;
         run_len      = 0;
         line_held    = 1'b0;
         return;
      end
      if (ch != adl_pkg::NEWLINE) begin
         // drop characters beyond the line store
         if (incoming_len < LINE_MAX) begin
            incoming_text[incoming_len] = ch;
            incoming_len++;
         end
         return;
      end
      if (!line_held) begin
         start_new_run();
      end else begin
         held_span = compared_span(held_len);
         new_span  = compared_span(incoming_len);
         mismatch  = (held_span != new_span);
         for (int unsigned i = 0; !mismatch && i < held_span; i++)
            if (held_text[i] != incoming_text[i]) mismatch = 1'b1;
         if (!mismatch) begin
            if (run_len != adl_pkg::COUNT_MAX) run_len++;
         end else begin
            emit_held_run();
            start_new_run();
         end
      end
      incoming_len = 0;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word: expected none, actual text %h bytes %0d run %0d last %0b",
                     $time, rsp_text_word, rsp_byte_count, rsp_run_count, rsp_last_word);
            errors++;
         end else begin
            head_word = expected_words.pop_front();
            if (rsp_text_word !== head_word.text) begin
               $display("%0t: text_word expected %h actual %h", $time, head_word.text,
                        rsp_text_word);
               errors++;
            end
            if (rsp_byte_count !== head_word.nbytes) begin
               $display("%0t: byte_count expected %0d actual %0d", $time, head_word.nbytes,
                        rsp_byte_count);
               errors++;
            end
            if (rsp_run_count !== head_word.count) begin
               $display("%0t: run_count expected %0d actual %0d", $time, head_word.count,
                        rsp_run_count);
               errors++;
            end
            if (rsp_last_word !== head_word.last) begin
               $display("%0t: last_word expected %0b actual %0b", $time, head_word.last,
                        rsp_last_word);
               errors++;
            end
         end
      end
   end

   // result receiver: random stalls, plus a long hold-off on request
   initial begin
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold_req = 1'b0;
         end else if (ready_gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // offer one byte transaction and hold it until accepted; valid stays high unless a gap follows
   task automatic send_item(bit [7:0] ch, bit eoi);
      req_valid        <= 1'b1;
      req_in_byte      <= ch;
      req_end_of_input <= eoi;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      predict_dedup(ch, eoi);
      if (send_gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat (pick_gap()) @(posedge clock);
      end
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
      send_item(adl_pkg::NEWLINE, 1'b0);
   endtask

   task automatic send_bytes(bit [7:0] text[$], bit terminate);
      foreach (text[i]) send_item(text[i], 1'b0);
      if (terminate) send_item(adl_pkg::NEWLINE, 1'b0);
   endtask

   task automatic end_stream();
      send_item(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // stop offering, wait for every outstanding word, then let a flush in flight finish
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [adl_pkg::CSR_IDX_W-1:0] idx,
                            logic [adl_pkg::CW_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         adl_pkg::CSR_COUNT_MODE:    cfg_count_mode    = value[0];
         adl_pkg::CSR_UNIQUE_ONLY:   cfg_unique_only   = value[0];
         adl_pkg::CSR_COMPARE_WIDTH: cfg_compare_width = value;
         default: ;
      endcase
   endtask

   task automatic set_config(bit count_mode, bit unique_only, bit [adl_pkg::CW_W-1:0] width);
      wait_until_drained();
      write_csr(adl_pkg::CSR_COUNT_MODE, adl_pkg::CW_W'(count_mode));
      write_csr(adl_pkg::CSR_UNIQUE_ONLY, adl_pkg::CW_W'(unique_only));
      write_csr(adl_pkg::CSR_COMPARE_WIDTH, width);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_empty_stream();
      set_config(1'b0, 1'b0, 10'd0);
      end_stream();
      send_item(adl_pkg::NEWLINE, 1'b1);
   endtask

   task automatic test_plain_runs();
      bit [7:0] odd_line[$];
      odd_line = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55, 8'hAA};
      send_text("ab");
      send_text("ab");
      send_text("abc");
      send_text("");
      send_text("");
      send_bytes(odd_line, 1'b1);
      // unterminated tail is dropped at end of stream
      send_bytes('{8'h74, 8'h61}, 1'b0);
      end_stream();
   endtask

   task automatic test_count_and_unique();
      set_config(1'b1, 1'b1, 10'd0);
      send_text("q");
      send_text("q");
      send_text("r");
      send_text("s");
      send_text("s");
      end_stream();
   endtask

   task automatic test_compare_width();
      set_config(1'b1, 1'b0, 10'd1);
      send_text("ab");
      send_text("ac");
      send_text("b");
      send_text("");
      end_stream();
      set_config(1'b1, 1'b0, 10'd512);
      send_text("abc");
      send_text("abc");
      send_text("abd");
      end_stream();
   endtask

   task automatic test_line_lengths();
      bit [7:0] long_a[$];
      bit [7:0] long_b[$];
      set_config(1'b1, 1'b0, 10'd0);
      repeat (530) long_a.push_back(random_text_byte());
      long_b = long_a;
      // differ only beyond the line store, so the two still match
      for (int i = 515; i < 530; i++) long_b[i] = random_text_byte();
      send_bytes(long_a, 1'b1);
      send_bytes(long_b, 1'b1);
      send_text("ninechars");
      send_text("eightchr");
      end_stream();
   endtask

   task automatic test_backpressure();
      bit [7:0] line[$];
      set_config(1'b1, 1'b0, 10'd0);
      send_gaps_on  = 1'b0;
      ready_gaps_on = 1'b1;
      long_hold_req = 1'b1;
      for (int k = 0; k < 12; k++) begin
         line.delete();
         line.push_back(8'(8'h41 + k));
         repeat ($urandom_range(7, 17)) line.push_back(random_text_byte());
         send_bytes(line, 1'b1);
      end
      end_stream();
      send_gaps_on = 1'b1;
      wait_until_drained();
   endtask

   task automatic test_random_traffic();
      bit [7:0]               prev[$];
      bit [7:0]               line[$];
      bit [adl_pkg::CW_W-1:0] width;
      int unsigned            items_start;
      int unsigned            pick;
      items_start = items_sent;
      while (items_sent - items_start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0:       width = 10'd0;
            1:       width = 10'd1;
            2:       width = 10'd512;
            default: width = adl_pkg::CW_W'($urandom_range(2, 12));
         endcase
         set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), width);
         send_gaps_on  = ($urandom_range(0, 3) != 0);
         ready_gaps_on = ($urandom_range(0, 3) != 0);
         prev.delete();
         repeat (14) begin
            pick = $urandom_range(0, 19);
            if (pick < 7) begin
               send_bytes(prev, 1'b1);
            end else if (pick < 11) begin
               // same line with an extended tail or with one byte changed
               line = prev;
               if (line.size() == 0 || $urandom_range(0, 1) == 0)
                  repeat ($urandom_range(1, 3)) line.push_back(random_text_byte());
               else
                  line[$urandom_range(0, line.size() - 1)] = random_text_byte();
               send_bytes(line, 1'b1);
               prev = line;
            end else if (pick < 18) begin
               line.delete();
               repeat (($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(0, 12))
                  line.push_back(random_text_byte());
               send_bytes(line, 1'b1);
               prev = line;
            end else if (pick == 18) begin
               repeat ($urandom_range(1, 6)) send_item(8'($urandom_range(0, 255)), 1'b0);
            end else begin
               if ($urandom_range(0, 1) == 0)
                  repeat ($urandom_range(1, 4)) send_item(random_text_byte(), 1'b0);
               end_stream();
            end
         end
         end_stream();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_stream();
      test_plain_runs();
      test_count_and_unique();
      test_compare_width();
      test_line_lengths();
      test_backpressure();
      test_random_traffic();
      wait_until_drained();
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
